### src/pbil_pkg.sv
// ----------------------------------------------------------------------------
// PBIL probability vector engine package
// Shared types, constants and codes for the probability store engine.
// ----------------------------------------------------------------------------
package pbil_pkg;

	// Probability fraction format, unsigned Q0.PROB_WIDTH
	localparam int PROB_WIDTH = 16;
	localparam int PROB_ONE   = 1 << PROB_WIDTH;

	typedef logic [PROB_WIDTH-1:0] prob_t;
	// multiplier operand: holds ONE minus a fraction, so one bit wider
	typedef logic [PROB_WIDTH:0]   mult_t;

	// two-term product sum from the serial multiplier
	localparam int PROD_W = 2 * PROB_WIDTH + 2;
	typedef logic [PROD_W-1:0] prod_t;

	// selected count and ones count
	localparam int SEL_W = 8;
	typedef logic [SEL_W-1:0] sel_t;
	localparam int MAX_SELECTED = 255;

	// gamma * ones fits in this many bits
	localparam int DIVD_W = PROB_WIDTH + SEL_W;
	typedef logic [DIVD_W-1:0] divd_t;

	localparam int IDX_W      = 12;
	localparam int N_BITS_DEF = 4096;

	// fixed probability values
	localparam prob_t PROB_HALF = prob_t'(PROB_ONE / 2);
	localparam prob_t SEED_HI   = prob_t'((99 * PROB_ONE + 50) / 100);
	localparam prob_t SEED_LO   = prob_t'((PROB_ONE + 50) / 100);

	// sequencer step counts
	localparam int MUL_STEPS = PROB_WIDTH + 1;
	localparam int DIV_STEPS = DIVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAMMA     = 2'd0,
		REG_SELECTED  = 2'd1,
		REG_MUT_RATE  = 2'd2,
		REG_MUT_SHIFT = 2'd3
	} cfg_reg_t;

	localparam prob_t GAMMA_RST     = prob_t'(655);
	localparam sel_t  SELECTED_RST  = sel_t'(1);
	localparam prob_t MUT_RATE_RST  = prob_t'(1311);
	localparam prob_t MUT_SHIFT_RST = prob_t'(3277);

	// Operation codes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_LEARN  = 2'd1,
		OP_MUTATE = 2'd2,
		OP_SEED   = 2'd3
	} op_t;

	// Request and response words
	typedef struct packed {
		op_t              req_type;
		logic [IDX_W-1:0] bit_index;
		prob_t            random_a;
		prob_t            random_b;
		sel_t             ones_count;
		logic             seed_bit;
	} req_t;

	typedef struct packed {
		logic  sampled_bit;
		prob_t probability_q16;
	} rsp_t;

endpackage

### src/pbil_stream_if.sv
// ----------------------------------------------------------------------------
// PBIL stream interface
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface pbil_stream_if #(
	parameter type data_t = logic
);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### src/pbil_ram.sv
// ----------------------------------------------------------------------------
// PBIL generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pbil_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/pbil_mul.sv
// ----------------------------------------------------------------------------
// PBIL serial multiplier
// Bit-serial shift-add unit forming ma*xa + mb*xb, one multiplier bit per
// step, LSB first. The product is complete after MUL_STEPS steps.
// ----------------------------------------------------------------------------
module pbil_mul import pbil_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  logic  step,
	input  prob_t ma,
	input  prob_t mb,
	input  mult_t xa,
	input  mult_t xb,
	output prod_t product
);

	prob_t                 ma_q, mb_q;
	mult_t                 xa_q, xb_q;
	logic [PROB_WIDTH:0]   hi_q;
	logic [PROB_WIDTH:0]   lo_q;
	logic [PROB_WIDTH+1:0] sum;

	// partial sum: running high half plus the selected multiplicands
	always_comb begin
		sum = {1'b0, hi_q}
			+ (xa_q[0] ? {2'b00, ma_q} : '0)
			+ (xb_q[0] ? {2'b00, mb_q} : '0);
	end

	// operand load, then shift right one bit per step
	always_ff @(posedge clk) begin
		if (load) begin
			ma_q <= ma;
			mb_q <= mb;
			xa_q <= xa;
			xb_q <= xb;
			hi_q <= '0;
			lo_q <= '0;
		end else if (step) begin
			xa_q <= xa_q >> 1;
			xb_q <= xb_q >> 1;
			hi_q <= sum[PROB_WIDTH+1:1];
			lo_q <= {sum[0], lo_q[PROB_WIDTH:1]};
		end
	end

	assign product = {hi_q, lo_q};

endmodule

### src/pbil_div.sv
// ----------------------------------------------------------------------------
// PBIL serial divider
// Restoring divider, one quotient bit per step, MSB first. The quotient
// replaces the dividend in its shift register after DIV_STEPS steps.
// ----------------------------------------------------------------------------
module pbil_div import pbil_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  logic  step,
	input  divd_t dividend,
	input  sel_t  divisor,
	output divd_t quotient
);

	divd_t          dq_q;
	sel_t           d_q;
	sel_t           r_q;
	logic [SEL_W:0] trial;
	logic           ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {r_q, dq_q[DIVD_W-1]};
		ge    = (trial >= {1'b0, d_q});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dq_q <= dividend;
			d_q  <= divisor;
			r_q  <= '0;
		end else if (step) begin
			r_q  <= ge ? sel_t'(trial - {1'b0, d_q}) : trial[SEL_W-1:0];
			dq_q <= {dq_q[DIVD_W-2:0], ge};
		end
	end

	assign quotient = dq_q;

endmodule

### src/pbil_probability_vector_engine.sv
// Request path: S_READ, S_SETUP, then S_FIN for sample, seed, non-firing mutate and
// out-of-range index; a firing mutate first runs the 17-step serial multiplier (S_MUL),
// a learn that and then the 24-step serial divider (S_DLOAD, S_DIV). One request at a
// time: a new word is taken only once the last has left S_FIN, which waits on rsp.
// After reset the store (N_BITS entries, 4096 by default) is swept to one half;
// no request is accepted during the sweep, configuration writes are.
// ----------------------------------------------------------------------------
// PBIL probability vector engine
// Per-bit probability store with sample, learn, mutate and seed operations,
// built around a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
module pbil_probability_vector_engine import pbil_pkg::*; #(
	parameter int N_BITS = N_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pbil_stream_if.sink          req,
	pbil_stream_if.source        rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int ADDR_W = (N_BITS > 1) ? $clog2(N_BITS) : 1;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SETUP,
		S_MUL,
		S_DLOAD,
		S_DIV,
		S_FIN
	} state_t;

	state_t     state_q;
	logic [CNT_W-1:0] cnt_q;
	addr_t      clr_q;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	req_t       item_q;
	logic       in_range_q;
	prob_t      p_q;
	logic       fire_q;

	prob_t      gamma_q;
	sel_t       sel_q;
	prob_t      rate_q;
	prob_t      shift_q;

	logic       accept;
	logic       out_free;
	addr_t      addr;
	prob_t      rdata;
	sel_t       sel_eff;
	sel_t       ones_k;
	logic       is_mutate;
	prob_t      mul_mb;
	mult_t      mul_xa, mul_xb;
	prod_t      prod_a, prod_b;
	divd_t      quot;
	prob_t      keep;
	logic [PROB_WIDTH:0] learn_sum;
	prob_t      learn_v;
	prob_t      mut_raw;
	prob_t      mut_v;
	rsp_t       result;
	logic       ram_we;
	addr_t      ram_waddr;
	prob_t      ram_wdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			sel_q   <= SELECTED_RST;
			rate_q  <= MUT_RATE_RST;
			shift_q <= MUT_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAMMA:     gamma_q <= prob_t'(cfg_data);
				REG_SELECTED:  sel_q   <= cfg_data[SEL_W-1:0];
				REG_MUT_RATE:  rate_q  <= prob_t'(cfg_data);
				REG_MUT_SHIFT: shift_q <= prob_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Handshakes
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign addr      = addr_t'(item_q.bit_index);
	assign is_mutate = (item_q.req_type == OP_MUTATE);

	// Effective selected count, and ones count saturated to it
	always_comb begin
		if (sel_q == '0) begin
			sel_eff = sel_t'(1);
		end else if (32'(sel_q) > MAX_SELECTED) begin
			sel_eff = sel_t'(MAX_SELECTED);
		end else begin
			sel_eff = sel_q;
		end
		ones_k = (item_q.ones_count > sel_eff) ? sel_eff : item_q.ones_count;
	end

	// Multiplier A operands: p*(ONE-gamma) for learn,
	// p*(ONE-shift) + random_b*shift for mutate
	always_comb begin
		if (is_mutate) begin
			mul_mb = item_q.random_b;
			mul_xa = mult_t'(PROB_ONE) - {1'b0, shift_q};
			mul_xb = {1'b0, shift_q};
		end else begin
			mul_mb = '0;
			mul_xa = mult_t'(PROB_ONE) - {1'b0, gamma_q};
			mul_xb = '0;
		end
	end

	pbil_ram #(
		.WIDTH (PROB_WIDTH),
		.DEPTH (N_BITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	pbil_mul u_mul_a (
		.clk     (clk),
		.load    (state_q == S_SETUP),
		.step    (state_q == S_MUL),
		.ma      (rdata),
		.mb      (mul_mb),
		.xa      (mul_xa),
		.xb      (mul_xb),
		.product (prod_a)
	);

	// Multiplier B: gamma * ones, the dividend of the learn gain
	pbil_mul u_mul_b (
		.clk     (clk),
		.load    (state_q == S_SETUP),
		.step    (state_q == S_MUL),
		.ma      (gamma_q),
		.mb      ('0),
		.xa      (mult_t'(ones_k)),
		.xb      ('0),
		.product (prod_b)
	);

	pbil_div u_div (
		.clk      (clk),
		.load     (state_q == S_DLOAD),
		.step     (state_q == S_DIV),
		.dividend (prod_b[DIVD_W-1:0]),
		.divisor  (sel_eff),
		.quotient (quot)
	);

	// Final entry value per operation
	always_comb begin
		keep      = prod_a[2*PROB_WIDTH-1:PROB_WIDTH];
		learn_sum = {1'b0, keep} + {1'b0, quot[PROB_WIDTH-1:0]};
		learn_v   = learn_sum[PROB_WIDTH] ? '1 : learn_sum[PROB_WIDTH-1:0];
		mut_raw   = fire_q ? keep : p_q;
		mut_v     = (mut_raw == '0) ? prob_t'(1) : mut_raw;
		result    = '0;
		unique case (item_q.req_type)
			OP_SAMPLE: begin
				result.sampled_bit     = (item_q.random_a <= p_q);
				result.probability_q16 = p_q;
			end
			OP_LEARN:  result.probability_q16 = learn_v;
			OP_MUTATE: result.probability_q16 = mut_v;
			OP_SEED:   result.probability_q16 = item_q.seed_bit ? SEED_HI : SEED_LO;
			default:   result = '0;
		endcase
		if (!in_range_q) begin
			result = '0;
		end
	end

	// Store write: clearing sweep or write-back of the finished word
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = PROB_HALF;
		end else begin
			ram_we    = (state_q == S_FIN) && out_free && in_range_q;
			ram_waddr = addr;
			ram_wdata = result.probability_q16;
		end
	end

	// Request payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= req.data;
			in_range_q <= (32'(req.data.bit_index) < N_BITS);
		end
		if (state_q == S_SETUP) begin
			p_q    <= rdata;
			fire_q <= (item_q.random_a < rate_q);
		end
	end

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// response valid: set by a finished word, cleared once taken
			if ((state_q == S_FIN) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(N_BITS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					cnt_q <= '0;
					if (!in_range_q) begin
						state_q <= S_FIN;
					end else if (item_q.req_type == OP_LEARN) begin
						state_q <= S_MUL;
					end else if (is_mutate && (item_q.random_a < rate_q)) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= (item_q.req_type == OP_LEARN) ? S_DLOAD : S_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DLOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						rsp_q   <= result;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sim/pbil_probability_vector_engine_tb.sv
// ----------------------------------------------------------------------------
// PBIL probability vector engine testbench
// Starts with a scripted run of sample, learn, mutate and seed words. Register
// writes in the script move the settings to their extremes. Random phases, each
// with its own settings, follow in pairs sharing an idling pattern. Responses are
// checked against a known value or a local model of the store and registers.
// ----------------------------------------------------------------------------
module pbil_probability_vector_engine_tb;
	import pbil_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int SETTLE_CYCLES   = 60;
	localparam int PHASES          = 6;
	localparam int PHASE_WORDS     = 88;
	localparam int HOT_ENTRIES     = 16;

	// one line of the scripted part: a register write or a request word
	typedef struct {
		bit       is_write;
		cfg_reg_t addr;
		prob_t    value;
		req_t     word;
		bit       known;
		rsp_t     known_rsp;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	pbil_stream_if #(.data_t(req_t)) req_if ();
	pbil_stream_if #(.data_t(rsp_t)) rsp_if ();

	pbil_probability_vector_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// model state: probability store and register copies
	prob_t prob_mem [N_BITS_DEF];
	prob_t gamma_sh;
	sel_t  selected_sh;
	prob_t rate_sh;
	prob_t shift_sh;

	rsp_t  rsp_due [$];
	int    fail_count  = 0;
	int    quiet_count = 0;
	int    word_gap_pct;
	int    rsp_stall_pct;
	bit    cfg_open;

	script_row_t script [$];

	// apply one operation to the model store, return the response word
	function automatic rsp_t apply_pbil_op(input req_t w);
		bit [63:0] p, sel, k, g, s, keep, gain;
		rsp_t      r;
		p = prob_mem[w.bit_index];
		r.sampled_bit = 1'b0;
		case (w.req_type)
			OP_SAMPLE: r.sampled_bit = (w.random_a <= p);
			OP_LEARN: begin
				sel = (selected_sh == 0) ? 64'd1 : 64'(selected_sh);
				if (sel > MAX_SELECTED) sel = MAX_SELECTED;
				k = (w.ones_count > sel) ? sel : 64'(w.ones_count);
				g = gamma_sh;
				keep = (p * (PROB_ONE - g)) >> PROB_WIDTH;
				gain = (g * k) / sel;
				p = keep + gain;
				if (p > PROB_ONE - 1) p = PROB_ONE - 1;
			end
			OP_MUTATE: begin
				if (w.random_a < rate_sh) begin
					s = shift_sh;
					p = (p * (PROB_ONE - s) + 64'(w.random_b) * s) >> PROB_WIDTH;
					if (p > PROB_ONE - 1) p = PROB_ONE - 1;
				end
				// an entry never sits at zero after mutation
				if (p == 0) p = 1;
			end
			default: p = w.seed_bit ? SEED_HI : SEED_LO;
		endcase
		prob_mem[w.bit_index] = prob_t'(p);
		r.probability_q16 = prob_t'(p);
		return r;
	endfunction

	function automatic req_t mk_word(input op_t op, input int idx, input int ra,
			input int rb, input int ones, input bit seed);
		req_t w;
		w.req_type   = op;
		w.bit_index  = idx[IDX_W-1:0];
		w.random_a   = prob_t'(ra);
		w.random_b   = prob_t'(rb);
		w.ones_count = sel_t'(ones);
		w.seed_bit   = seed;
		return w;
	endfunction

	function automatic script_row_t w_row(input req_t w);
		script_row_t r;
		r.is_write  = 1'b0;
		r.addr      = REG_GAMMA;
		r.value     = '0;
		r.word      = w;
		r.known     = 1'b0;
		r.known_rsp = '0;
		return r;
	endfunction

	function automatic script_row_t k_row(input req_t w, input bit b, input int p);
		script_row_t r;
		r = w_row(w);
		r.known = 1'b1;
		r.known_rsp.sampled_bit = b;
		r.known_rsp.probability_q16 = prob_t'(p);
		return r;
	endfunction

	function automatic script_row_t c_row(input cfg_reg_t a, input int v);
		script_row_t r;
		r = w_row('0);
		r.is_write = 1'b1;
		r.addr     = a;
		r.value    = prob_t'(v);
		return r;
	endfunction

	function automatic prob_t near_value(input prob_t centre);
		int t;
		t = int'(centre) + int'($urandom_range(4)) - 2;
		if (t < 0) t = 0;
		if (t > PROB_ONE - 1) t = PROB_ONE - 1;
		return prob_t'(t);
	endfunction

	// random word: mostly a few hot entries so that operations build on each other
	function automatic req_t random_word();
		req_t w;
		w = req_t'({$urandom, $urandom});
		w.req_type = op_t'($urandom_range(3));
		if ($urandom_range(99) < 80) w.bit_index = IDX_W'($urandom_range(HOT_ENTRIES - 1));
		if (w.req_type == OP_MUTATE && $urandom_range(1)) w.random_a = near_value(rate_sh);
		if (w.req_type == OP_SAMPLE && $urandom_range(1))
			w.random_a = near_value(prob_mem[w.bit_index]);
		if ($urandom_range(99) < 70)
			w.ones_count = sel_t'($urandom_range(selected_sh == 0 ? 1 : selected_sh));
		return w;
	endfunction

	// lower the request valid, wait for every response, let the pipe go quiet
	task automatic quiesce();
		req_if.valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t a, input prob_t v);
		if (!cfg_open) quiesce();
		cfg_open = 1'b1;
		cfg_we    <= 1'b1;
		cfg_index <= a;
		cfg_data  <= v;
		@(posedge clk);
		case (a)
			REG_GAMMA:     gamma_sh    = v;
			REG_SELECTED:  selected_sh = v[SEL_W-1:0];
			REG_MUT_RATE:  rate_sh     = v;
			REG_MUT_SHIFT: shift_sh    = v;
		endcase
	endtask

	task automatic close_cfg();
		if (cfg_open) begin
			cfg_we <= 1'b0;
			cfg_open = 1'b0;
		end
	endtask

	task automatic set_config(input prob_t g, input int sel, input prob_t r, input prob_t s);
		write_cfg(REG_GAMMA, g);
		// upper byte is noise, the register keeps the low eight bits
		write_cfg(REG_SELECTED, {8'($urandom), 8'(sel)});
		write_cfg(REG_MUT_RATE, r);
		write_cfg(REG_MUT_SHIFT, s);
		close_cfg();
	endtask

	// present one word, wait for it to be taken, log its expected response
	task automatic send_word(input req_t w, input bit known, input rsp_t known_rsp);
		rsp_t fore;
		close_cfg();
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		do @(posedge clk); while (!req_if.ready);
		fore = apply_pbil_op(w);
		rsp_due.push_back(known ? known_rsp : fore);
		if ($urandom_range(99) < word_gap_pct) begin
			req_if.valid <= 1'b0;
			req_if.data  <= req_t'({$urandom, $urandom});
			do @(posedge clk); while ($urandom_range(99) < word_gap_pct);
		end
	endtask

	// response checker, receiver stalls and watchdog
	always @(posedge clk) begin
		rsp_t got, want;
		if (rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (rsp_due.size() == 0) begin
				$error("response word with nothing outstanding: bit %0d prob %0d",
					got.sampled_bit, got.probability_q16);
				fail_count++;
			end else begin
				want = rsp_due.pop_front();
				if (got.sampled_bit !== want.sampled_bit) begin
					$error("sampled_bit: expected %0d, got %0d",
						want.sampled_bit, got.sampled_bit);
					fail_count++;
				end
				if (got.probability_q16 !== want.probability_q16) begin
					$error("probability_q16: expected %0d, got %0d",
						want.probability_q16, got.probability_q16);
					fail_count++;
				end
			end
		end
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= WATCHDOG_CYCLES) begin
			$display("pbil_probability_vector_engine verification failed");
			$finish;
		end
		rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// scripted part: reset values, boundaries, then both extremes of the settings
	initial begin
		script.push_back(k_row(mk_word(OP_SAMPLE, 0, 0, 0, 0, 0), 1, 32768));
		script.push_back(k_row(mk_word(OP_SAMPLE, 4095, 65535, 65535, 255, 1), 0, 32768));
		script.push_back(k_row(mk_word(OP_SAMPLE, 5, 32768, 0, 0, 0), 1, 32768));
		script.push_back(k_row(mk_word(OP_SAMPLE, 5, 32769, 0, 0, 0), 0, 32768));
		script.push_back(k_row(mk_word(OP_SEED, 1, 0, 0, 0, 1), 0, 64881));
		script.push_back(k_row(mk_word(OP_SEED, 2, 0, 0, 0, 0), 0, 655));
		script.push_back(k_row(mk_word(OP_SAMPLE, 1, 64881, 0, 0, 0), 1, 64881));
		script.push_back(w_row(mk_word(OP_LEARN, 3, 0, 0, 1, 0)));
		// ones above the selected count
		script.push_back(w_row(mk_word(OP_LEARN, 3, 0, 0, 255, 0)));
		script.push_back(w_row(mk_word(OP_LEARN, 4, 0, 0, 0, 0)));
		script.push_back(w_row(mk_word(OP_MUTATE, 6, 0, 65535, 0, 0)));
		script.push_back(w_row(mk_word(OP_MUTATE, 6, 65535, 0, 0, 0)));
		// gate at exactly the rate does not fire
		script.push_back(w_row(mk_word(OP_MUTATE, 7, 1311, 65535, 0, 0)));
		script.push_back(w_row(mk_word(OP_MUTATE, 8, 1310, 0, 0, 0)));
		// full learning rate, zero selected count taken as one, full mutation
		script.push_back(c_row(REG_GAMMA, 65535));
		script.push_back(c_row(REG_SELECTED, 0));
		script.push_back(c_row(REG_MUT_RATE, 65535));
		script.push_back(c_row(REG_MUT_SHIFT, 65535));
		script.push_back(w_row(mk_word(OP_LEARN, 9, 0, 0, 0, 0)));
		// entry at zero, gate closed: clamped to the smallest fraction
		script.push_back(w_row(mk_word(OP_MUTATE, 9, 65535, 0, 0, 0)));
		script.push_back(w_row(mk_word(OP_LEARN, 10, 0, 0, 200, 0)));
		script.push_back(w_row(mk_word(OP_MUTATE, 10, 0, 0, 0, 0)));
		script.push_back(w_row(mk_word(OP_SAMPLE, 10, 1, 0, 0, 0)));
		// settings at their low ends, largest selected count
		script.push_back(c_row(REG_GAMMA, 0));
		script.push_back(c_row(REG_SELECTED, 255));
		script.push_back(c_row(REG_MUT_RATE, 0));
		script.push_back(c_row(REG_MUT_SHIFT, 0));
		script.push_back(w_row(mk_word(OP_LEARN, 11, 0, 0, 255, 0)));
		script.push_back(w_row(mk_word(OP_MUTATE, 11, 0, 65535, 0, 0)));
		script.push_back(w_row(mk_word(OP_SEED, 4095, 0, 0, 0, 1)));
		script.push_back(w_row(mk_word(OP_LEARN, 4095, 0, 0, 128, 0)));
	end

	// main sequence
	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_GAMMA;
		cfg_data     <= '0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		cfg_open = 1'b0;
		foreach (prob_mem[i]) prob_mem[i] = PROB_HALF;
		gamma_sh    = GAMMA_RST;
		selected_sh = SELECTED_RST;
		rate_sh     = MUT_RATE_RST;
		shift_sh    = MUT_SHIFT_RST;
		word_gap_pct  = 32;
		rsp_stall_pct = 51;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_write)
				write_cfg(script[i].addr, script[i].value);
			else
				send_word(script[i].word, script[i].known, script[i].known_rsp);
		end

		// random phases, each with its own settings; each pair shares an idling pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_config(prob_t'($urandom), $urandom_range(1, 16), 16'h8000,
					prob_t'($urandom));
				1: set_config(16'hFFFF, 255, 16'hFFFF, 16'h0000);
				2: set_config(16'h0000, 1, 16'h0000, 16'hFFFF);
				3: set_config(prob_t'($urandom), $urandom_range(255), prob_t'($urandom),
					prob_t'($urandom));
				default: set_config(prob_t'($urandom), $urandom_range(1, 40),
					prob_t'($urandom), prob_t'($urandom));
			endcase
			if (ph >= 4) begin
				word_gap_pct  = 0;
				rsp_stall_pct = 0;
			end else if (ph >= 2) begin
				word_gap_pct  = 51;
				rsp_stall_pct = 32;
			end
			for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word(), 1'b0, '0);
		end

		quiesce();
		if (fail_count == 0)
			$display("pbil_probability_vector_engine verification clean");
		else
			$display("pbil_probability_vector_engine verification failed");
		$finish;
	end

endmodule
